>>> src/rtm_pkg.sv
`timescale 1ns / 1ps

package rtm_pkg;

    localparam int CODE_W     = 15;
    localparam int TEMP_W     = 12;
    localparam int LIMIT_W    = 12;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIP_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_COUNT  = 2'd2;

    localparam logic [LIMIT_W-1:0] ALARM_LIMIT_RST = 12'd1600;
    localparam logic [LIMIT_W-1:0] TRIP_LIMIT_RST  = 12'd1760;
    localparam logic [HOLD_W-1:0]  HOLD_COUNT_RST  = 16'd0;

    localparam int RAD_W      = 48;
    localparam int ROOT_W     = 24;
    localparam int REM_W      = 27;
    localparam int SQRT_STEPS = 24;
    localparam int STEP_W     = 5;

    localparam logic signed [16:0] CODE_MID   = 17'sd8192;
    localparam logic signed [32:0] LIN_SLOPE  = 33'sd2887500000;
    localparam logic signed [49:0] OFFSET_SQ  = 50'sd156414043033600;
    localparam logic signed [25:0] ROUND_OFFS = 26'sd12506675;
    localparam logic signed [25:0] DIV_CLAMP  = 26'sd942711;
    localparam logic [20:0]        RECIP      = 21'd1162058;
    localparam int                 RECIP_SH   = 28;
    localparam logic [7:0]         LIN_DIV    = 8'd231;
    localparam logic [TEMP_W-1:0]  TEMP_MAX   = 12'd4080;

    typedef struct packed {
        logic load;
        logic mul;
        logic sqrt_step;
        logic div;
        logic corr;
        logic update;
    } rtm_cmd_t;

    typedef struct packed {
        logic need_lin;
    } rtm_stat_t;

endpackage

>>> src/rtm_if.sv
`timescale 1ns / 1ps

interface rtm_sample_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [1:0] channel_index;
    logic [7:0] fault_byte;
    logic [7:0] code_high;
    logic [7:0] code_low;

    modport source (output valid, command, channel_index, fault_byte, code_high, code_low,
                    input ready);
    modport sink (input valid, command, channel_index, fault_byte, code_high, code_low,
                  output ready);
endinterface

interface rtm_result_if;
    logic                       valid;
    logic                       ready;
    logic [rtm_pkg::TEMP_W-1:0] temperature;
    logic [7:0]                 fault_code;
    logic                       out_of_range;
    logic                       alarm_flag;
    logic                       trip_flag;

    modport source (output valid, temperature, fault_code, out_of_range, alarm_flag, trip_flag,
                    input ready);
    modport sink (input valid, temperature, fault_code, out_of_range, alarm_flag, trip_flag,
                  output ready);
endinterface

>>> src/rtm_ctrl.sv
`timescale 1ns / 1ps

module rtm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  rtm_pkg::rtm_stat_t stat,
    output rtm_pkg::rtm_cmd_t  cmd
);
    import rtm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_CORR = 3'd4;
    localparam logic [2:0] ST_UPD  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SQRT_STEPS - 1);

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              accept;

    assign in_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_OUT) && out_ready);
    assign out_valid = (state_reg == ST_OUT);
    assign accept    = in_valid && in_ready;

    assign cmd.load      = accept;
    assign cmd.mul       = (state_reg == ST_MUL);
    assign cmd.sqrt_step = (state_reg == ST_SQRT);
    assign cmd.div       = (state_reg == ST_DIV);
    assign cmd.corr      = (state_reg == ST_CORR);
    assign cmd.update    = (state_reg == ST_UPD);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                step_next  = '0;
                state_next = stat.need_lin ? ST_SQRT : ST_UPD;
            end
            ST_SQRT:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DIV:  state_next = ST_CORR;
            ST_CORR: state_next = ST_UPD;
            ST_UPD:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = accept ? ST_MUL : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

>>> src/rtm_datapath.sv
`timescale 1ns / 1ps

module rtm_datapath #(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rtm_pkg::rtm_cmd_t              cmd,
    output rtm_pkg::rtm_stat_t             stat,
    input  logic                           cfg_write,
    input  logic [rtm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           command,
    input  logic [1:0]                     channel_index,
    input  logic [7:0]                     fault_byte,
    input  logic [7:0]                     code_high,
    input  logic [7:0]                     code_low,
    output logic [rtm_pkg::TEMP_W-1:0]     temperature,
    output logic [7:0]                     fault_code,
    output logic                           out_of_range,
    output logic                           alarm_flag,
    output logic                           trip_flag
);
    import rtm_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > HOLD_W) ? COUNT_WIDTH : HOLD_W;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic                   latch;
    } hold_t;

    logic [LIMIT_W-1:0] alarm_limit_reg;
    logic [LIMIT_W-1:0] trip_limit_reg;
    logic [HOLD_W-1:0]  hold_count_reg;

    logic              cmd_reg;
    logic [1:0]        ch_reg;
    logic [7:0]        fault_reg;
    logic              oor_reg;
    logic [CODE_W-1:0] code_reg;

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [12:0]       q0_reg;
    logic [19:0]       num_reg;
    logic              clamp_lo_reg;
    logic              clamp_hi_reg;
    logic [TEMP_W-1:0] temp_reg;

    logic [COUNT_WIDTH-1:0] alarm_cnt_reg  [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] trip_cnt_reg   [NUM_CHANNELS];
    logic                   alarm_lat_reg  [NUM_CHANNELS];
    logic                   trip_lat_reg   [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] alarm_cnt_next [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] trip_cnt_next  [NUM_CHANNELS];
    logic                   alarm_lat_next [NUM_CHANNELS];
    logic                   trip_lat_next  [NUM_CHANNELS];

    logic               no_fault;
    logic               ch_valid;
    logic               alarm_sel;
    logic               trip_sel;
    logic signed [16:0] delta;
    logic signed [49:0] lin_prod;
    logic signed [49:0] rad_full;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic signed [25:0] diff;
    logic [40:0]        quot_prod;
    logic [20:0]        back_prod;
    logic [20:0]        div_rem;
    logic [12:0]        quot;

    function automatic hold_t hold_step(
        input logic                   above,
        input logic [COUNT_WIDTH-1:0] count,
        input logic                   latch,
        input logic [HOLD_W-1:0]      hold
    );
        hold_t res;
        res.count = count;
        res.latch = latch;
        if (above)
        begin
            if (CMP_W'(count) < CMP_W'(hold))
            begin
                if (count != {COUNT_WIDTH{1'b1}})
                begin
                    res.count = count + 1'b1;
                end
            end
            else
            begin
                res.count = '0;
                res.latch = 1'b1;
            end
        end
        else
        begin
            res.count = '0;
        end
        return res;
    endfunction

    assign no_fault      = !cmd_reg && (fault_reg == 8'd0);
    assign ch_valid      = (int'(ch_reg) < NUM_CHANNELS);
    assign stat.need_lin = no_fault && !oor_reg;

    assign delta    = $signed({2'b00, code_reg}) - CODE_MID;
    assign lin_prod = 50'(delta) * 50'(LIN_SLOPE);
    assign rad_full = OFFSET_SQ - lin_prod;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    assign diff      = ROUND_OFFS - $signed({2'b00, root_reg});
    assign quot_prod = {21'd0, diff[19:0]} * {20'd0, RECIP};

    assign back_prod = {8'd0, q0_reg} * {13'd0, LIN_DIV};
    assign div_rem   = {1'b0, num_reg} - back_prod;
    assign quot      = (div_rem >= {13'd0, LIN_DIV}) ? (q0_reg + 1'b1) : q0_reg;

    always_comb
    begin
        hold_t ha;
        hold_t ht;
        alarm_sel = 1'b0;
        trip_sel  = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            alarm_cnt_next[i] = alarm_cnt_reg[i];
            trip_cnt_next[i]  = trip_cnt_reg[i];
            alarm_lat_next[i] = alarm_lat_reg[i];
            trip_lat_next[i]  = trip_lat_reg[i];
            ha = hold_step(temp_reg > alarm_limit_reg, alarm_cnt_reg[i], alarm_lat_reg[i],
                           hold_count_reg);
            ht = hold_step(temp_reg > trip_limit_reg, trip_cnt_reg[i], trip_lat_reg[i],
                           hold_count_reg);
            if (cmd_reg)
            begin
                alarm_lat_next[i] = 1'b0;
                trip_lat_next[i]  = 1'b0;
            end
            else if (no_fault && (int'(ch_reg) == i))
            begin
                alarm_cnt_next[i] = ha.count;
                alarm_lat_next[i] = ha.latch;
                trip_cnt_next[i]  = ht.count;
                trip_lat_next[i]  = ht.latch;
            end
            if (int'(ch_reg) == i)
            begin
                alarm_sel = alarm_lat_next[i];
                trip_sel  = trip_lat_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_limit_reg <= ALARM_LIMIT_RST;
            trip_limit_reg  <= TRIP_LIMIT_RST;
            hold_count_reg  <= HOLD_COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ALARM_LIMIT: alarm_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_TRIP_LIMIT:  trip_limit_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_HOLD_COUNT:  hold_count_reg  <= cfg_data[HOLD_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                alarm_cnt_reg[i] <= '0;
                trip_cnt_reg[i]  <= '0;
                alarm_lat_reg[i] <= 1'b0;
                trip_lat_reg[i]  <= 1'b0;
            end
        end
        else if (cmd.update && ch_valid)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                alarm_cnt_reg[i] <= alarm_cnt_next[i];
                trip_cnt_reg[i]  <= trip_cnt_next[i];
                alarm_lat_reg[i] <= alarm_lat_next[i];
                trip_lat_reg[i]  <= trip_lat_next[i];
            end
        end
        else if (cmd.update && cmd_reg)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                alarm_lat_reg[i] <= 1'b0;
                trip_lat_reg[i]  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= command;
            ch_reg    <= channel_index;
            fault_reg <= fault_byte;
            oor_reg   <= code_low[0];
            code_reg  <= {code_high, code_low[7:1]};
            temp_reg  <= '0;
        end
        if (cmd.mul)
        begin
            rad_reg  <= rad_full[RAD_W-1:0];
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.div)
        begin
            clamp_lo_reg <= (diff <= 26'sd0);
            clamp_hi_reg <= (diff >= DIV_CLAMP);
            num_reg      <= diff[19:0];
            q0_reg       <= quot_prod[RECIP_SH +: 13];
        end
        if (cmd.corr)
        begin
            if (clamp_lo_reg)
            begin
                temp_reg <= '0;
            end
            else if (clamp_hi_reg)
            begin
                temp_reg <= TEMP_MAX;
            end
            else
            begin
                temp_reg <= quot[TEMP_W-1:0];
            end
        end
        if (cmd.update)
        begin
            temperature  <= temp_reg;
            fault_code   <= cmd_reg ? 8'd0 : fault_reg;
            out_of_range <= no_fault && oor_reg;
            alarm_flag   <= ch_valid && alarm_sel;
            trip_flag    <= ch_valid && trip_sel;
        end
    end

endmodule

>>> src/rtd_temperature_monitor.sv
`timescale 1ns / 1ps

// RTD temperature monitor.
// sample channel (rtm_sample_if, valid/ready): command, channel_index, fault_byte and the
//   two converter code bytes. A transfer takes place when valid and ready are both high.
// result channel (rtm_result_if, valid/ready): linearized temperature in 1/16 degree,
//   echoed fault byte, out-of-range bit and the sticky alarm and trip flags of the channel.
// cfg_write/cfg_index/cfg_data: write alarm_limit (0), trip_limit (1), hold_count (2);
//   write only while no sample is in flight.
// Sequence: a clean sample runs the product stage, a bit-serial square root,
//   a reciprocal divide and its correction, then the flag update, before the result
//   is valid. Faulted, out-of-range and clear items skip the square root, divide and
//   correction and go from the product stage straight to the flag update.
// Throughput: one item at a time; a new sample is taken in the same cycle the pending
//   result is transferred, and no new sample is taken while one is in progress.
// Reset clears the limits to their defaults, all hold counters and sticky flags, and the controller.
// While the receiver stalls, the result holds steady and no new sample is taken.
module rtd_temperature_monitor #(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rtm_sample_if.sink                     sample,
    rtm_result_if.source                   result,
    input  logic                           cfg_write,
    input  logic [rtm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rtm_pkg::*;

    rtm_cmd_t  cmd;
    rtm_stat_t stat;

    rtm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rtm_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (sample.command),
        .channel_index (sample.channel_index),
        .fault_byte    (sample.fault_byte),
        .code_high     (sample.code_high),
        .code_low      (sample.code_low),
        .temperature   (result.temperature),
        .fault_code    (result.fault_code),
        .out_of_range  (result.out_of_range),
        .alarm_flag    (result.alarm_flag),
        .trip_flag     (result.trip_flag)
    );

endmodule

>>> src/rtm_checker.sv
`timescale 1ns / 1ps

module rtm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] temperature,
    input logic [7:0]  fault_code,
    input logic        out_of_range
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result shown in cycle after sample transfer");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> temperature <= 12'd4080)
        else $error("temperature beyond clamp");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (fault_code != 8'd0) |-> (temperature == 12'd0) && !out_of_range)
        else $error("faulted sample reports temperature");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> temperature == 12'd0)
        else $error("out-of-range sample reports temperature");

endmodule

bind rtd_temperature_monitor rtm_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample.valid),
    .in_ready     (sample.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .temperature  (result.temperature),
    .fault_code   (result.fault_code),
    .out_of_range (result.out_of_range)
);
